### design/ewhd_pkg.sv
// shared types, character constants and decode helpers for the encoded-word header decoder
// used by ewhd_front, ewhd_cmd_fifo and ewhd_back
`timescale 1ns / 1ps

package ewhd_pkg;

  // counter width that covers store depths up to 127
  localparam int CNT_W = 7;
  localparam int LIT_SLOTS = 4;

  localparam logic [7:0] CH_EQ    = 8'h3d;  // '='
  localparam logic [7:0] CH_QM    = 8'h3f;  // '?'
  localparam logic [7:0] CH_UNDER = 8'h5f;  // '_'
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_UQ    = 8'h51;  // 'Q'
  localparam logic [7:0] CH_LQ    = 8'h71;  // 'q'
  localparam logic [7:0] CH_UB    = 8'h42;  // 'B'
  localparam logic [7:0] CH_LB    = 8'h62;  // 'b'

  // one command: held spaces, then "=?charset" prefix, then literal bytes
  typedef struct packed {
    logic [CNT_W-1:0]          sp_n;
    logic                      pre;
    logic [CNT_W-1:0]          cs_n;
    logic [2:0]                lit_n;
    logic [LIT_SLOTS-1:0][7:0] lit;
    logic [LIT_SLOTS-1:0]      lit_fw;
  } cmd_t;

  // q and base64 decoder state
  typedef struct packed {
    logic [11:0] sextet;
    logic [3:0]  pend;
    logic        stopped;
    logic [1:0]  hex_phase;
    logic [7:0]  hn;
  } dec_t;

  typedef struct packed {
    dec_t       d;
    logic       emit;
    logic [7:0] b;
  } tc_t;

  function automatic cmd_t add_lit(cmd_t c, logic [7:0] b, logic fw);
    cmd_t r;
    r = c;
    r.lit[r.lit_n[1:0]] = b;
    r.lit_fw[r.lit_n[1:0]] = fw;
    r.lit_n = r.lit_n + 3'd1;
    return r;
  endfunction

  function automatic logic uses_store(cmd_t c);
    return (c.sp_n != '0) || c.pre;
  endfunction

  function automatic logic is_ws(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic logic [7:0] hex_value(logic [7:0] c);
    logic [7:0] lc;
    if (c >= 8'h30 && c <= 8'h39) begin
      return c - 8'h30;
    end
    lc = (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
    return lc - 8'd87;
  endfunction

  // {valid, sextet}
  function automatic logic [6:0] b64_value(logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h41 && c <= 8'h5a) begin
      v = c - 8'd65;
      return {1'b1, v[5:0]};
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      v = c - 8'd71;
      return {1'b1, v[5:0]};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = c + 8'd4;
      return {1'b1, v[5:0]};
    end else if (c == 8'h2b) begin
      return {1'b1, 6'd62};
    end else if (c == 8'h2f) begin
      return {1'b1, 6'd63};
    end
    return 7'd0;
  endfunction

  function automatic tc_t text_char(dec_t d, logic [7:0] letter, logic [7:0] c);
    tc_t        r;
    logic [6:0] bv;
    logic [3:0] sh;
    logic [11:0] shifted;
    r.d = d;
    r.emit = 1'b0;
    r.b = 8'h00;
    bv = 7'd0;
    sh = 4'd0;
    shifted = 12'd0;
    if (letter == CH_UQ || letter == CH_LQ) begin
      if (d.hex_phase == 2'd1) begin
        r.d.hn = hex_value(c);
        r.d.hex_phase = 2'd2;
      end else if (d.hex_phase == 2'd2) begin
        r.emit = 1'b1;
        r.b = {d.hn[3:0], 4'h0} + hex_value(c);
        r.d.hex_phase = 2'd0;
      end else if (c == CH_EQ) begin
        r.d.hex_phase = 2'd1;
      end else if (c == CH_UNDER) begin
        r.emit = 1'b1;
        r.b = CH_SPACE;
      end else begin
        r.emit = 1'b1;
        r.b = c;
      end
    end else if (!d.stopped) begin
      if (c == CH_EQ) begin
        r.d.stopped = 1'b1;
      end else begin
        bv = b64_value(c);
        if (bv[6]) begin
          r.d.sextet = {d.sextet[5:0], bv[5:0]};
          r.d.pend = d.pend + 4'd6;
          if (r.d.pend >= 4'd8) begin
            sh = r.d.pend - 4'd8;
            shifted = r.d.sextet >> sh;
            r.emit = 1'b1;
            r.b = shifted[7:0];
            r.d.pend = r.d.pend - 4'd8;
          end
        end
      end
    end
    return r;
  endfunction

endpackage

### design/ewhd_ram.sv
// generic single write port ram with registered read and read enable
// no dependencies
`timescale 1ns / 1ps

module ewhd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/ewhd_cmd_fifo.sv
// two-entry command queue between the parser front and the emitter back
// depends on ewhd_pkg
`timescale 1ns / 1ps

module ewhd_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ewhd_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output logic          valid_o,
  output ewhd_pkg::cmd_t cmd_o,
  output logic          full_o,
  output logic          store_busy_o
);

  ewhd_pkg::cmd_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign store_busy_o = (valid_o && ewhd_pkg::uses_store(mem_q[rd_ptr_q])) ||
                        (full_o && ewhd_pkg::uses_store(mem_q[~rd_ptr_q]));

endmodule

### design/ewhd_front.sv
// parser front: accepts header bytes, tracks word syntax, writes the stores, queues commands
// depends on ewhd_pkg
`timescale 1ns / 1ps

module ewhd_front #(
  parameter int CHARSET_MAX = 16,
  parameter int SPACE_HOLD = 16,
  localparam int CS_AW = (CHARSET_MAX > 1) ? $clog2(CHARSET_MAX) : 1,
  localparam int SP_AW = (SPACE_HOLD > 1) ? $clog2(SPACE_HOLD) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [7:0]       in_byte_i,
  input  logic             end_of_text_i,
  output logic             in_stall_o,
  input  logic             fifo_full_i,
  input  logic             store_busy_i,
  output logic             push_o,
  output ewhd_pkg::cmd_t   cmd_o,
  output logic             sp_we_o,
  output logic [SP_AW-1:0] sp_waddr_o,
  output logic             cs_we_o,
  output logic [CS_AW-1:0] cs_waddr_o,
  output logic [7:0]       wdata_o
);

  localparam int CSW = $clog2(CHARSET_MAX + 1);
  localparam int SPW = $clog2(SPACE_HOLD + 1);

  localparam logic [2:0] PH_PLAIN   = 3'd0;
  localparam logic [2:0] PH_EQ      = 3'd1;
  localparam logic [2:0] PH_CHARSET = 3'd2;
  localparam logic [2:0] PH_LETTER  = 3'd3;
  localparam logic [2:0] PH_AFTER   = 3'd4;
  localparam logic [2:0] PH_TEXT    = 3'd5;
  localparam logic [2:0] PH_LIT     = 3'd6;

  logic [2:0]     ph_q, ph_d;
  logic [CSW-1:0] cs_cnt_q, cs_cnt_d;
  logic [7:0]     letter_q, letter_d;
  logic [SPW-1:0] sp_cnt_q, sp_cnt_d;
  logic           bnd_q, bnd_d;
  ewhd_pkg::dec_t dec_q, dec_d;
  logic           qp_q, qp_d;

  ewhd_pkg::cmd_t cmd;
  ewhd_pkg::tc_t  tc;
  logic           do_plain, skip, accept;
  logic [7:0]     c;
  logic           is_q_or_b;

  assign c          = in_byte_i;
  assign in_stall_o = fifo_full_i || store_busy_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign wdata_o    = in_byte_i;
  assign is_q_or_b  = (letter_q == ewhd_pkg::CH_UQ) || (letter_q == ewhd_pkg::CH_LQ) ||
                      (letter_q == ewhd_pkg::CH_UB) || (letter_q == ewhd_pkg::CH_LB);

  always_comb begin
    ph_d       = ph_q;
    cs_cnt_d   = cs_cnt_q;
    letter_d   = letter_q;
    sp_cnt_d   = sp_cnt_q;
    bnd_d      = bnd_q;
    dec_d      = dec_q;
    qp_d       = qp_q;
    cmd        = '0;
    tc         = '0;
    do_plain   = 1'b0;
    skip       = 1'b0;
    sp_we_o    = 1'b0;
    sp_waddr_o = sp_cnt_q[SP_AW-1:0];
    cs_we_o    = 1'b0;
    cs_waddr_o = cs_cnt_q[CS_AW-1:0];

    unique case (ph_q)
      PH_EQ: begin
        if (c == ewhd_pkg::CH_QM) begin
          sp_cnt_d = '0;
          cs_cnt_d = '0;
          ph_d     = PH_CHARSET;
        end else begin
          if (sp_cnt_d != '0) begin
            cmd.sp_n = ewhd_pkg::CNT_W'(sp_cnt_d);
          end
          sp_cnt_d = '0;
          cmd      = ewhd_pkg::add_lit(cmd, ewhd_pkg::CH_EQ, 1'b0);
          bnd_d    = 1'b0;
          do_plain = 1'b1;
        end
      end
      PH_CHARSET: begin
        if (c == ewhd_pkg::CH_QM) begin
          ph_d = PH_LETTER;
        end else if (cs_cnt_q < CSW'(CHARSET_MAX)) begin
          cs_we_o  = 1'b1;
          cs_cnt_d = cs_cnt_q + 1'b1;
        end else begin
          cmd.pre  = 1'b1;
          cmd.cs_n = ewhd_pkg::CNT_W'(cs_cnt_q);
          cs_cnt_d = '0;
          bnd_d    = 1'b0;
          do_plain = 1'b1;
        end
      end
      PH_LETTER: begin
        letter_d = c;
        if (c == ewhd_pkg::CH_QM) begin
          cmd.pre  = 1'b1;
          cmd.cs_n = ewhd_pkg::CNT_W'(cs_cnt_q);
          cmd      = ewhd_pkg::add_lit(cmd, ewhd_pkg::CH_QM, 1'b0);
          cmd      = ewhd_pkg::add_lit(cmd, ewhd_pkg::CH_QM, 1'b0);
          qp_d     = 1'b0;
          ph_d     = PH_LIT;
        end else begin
          ph_d = PH_AFTER;
        end
      end
      PH_AFTER: begin
        if (c == ewhd_pkg::CH_QM) begin
          dec_d = '0;
          qp_d  = 1'b0;
          if (is_q_or_b) begin
            ph_d = PH_TEXT;
          end else begin
            cmd.pre  = 1'b1;
            cmd.cs_n = ewhd_pkg::CNT_W'(cs_cnt_q);
            cmd      = ewhd_pkg::add_lit(cmd, ewhd_pkg::CH_QM, 1'b0);
            cmd      = ewhd_pkg::add_lit(cmd, letter_q, 1'b0);
            cmd      = ewhd_pkg::add_lit(cmd, ewhd_pkg::CH_QM, 1'b0);
            ph_d     = PH_LIT;
          end
        end else begin
          cmd.pre  = 1'b1;
          cmd.cs_n = ewhd_pkg::CNT_W'(cs_cnt_q);
          cmd      = ewhd_pkg::add_lit(cmd, ewhd_pkg::CH_QM, 1'b0);
          cmd      = ewhd_pkg::add_lit(cmd, letter_q, 1'b0);
          cs_cnt_d = '0;
          bnd_d    = 1'b0;
          do_plain = 1'b1;
        end
      end
      PH_TEXT: begin
        if (qp_q) begin
          if (c == ewhd_pkg::CH_EQ) begin
            dec_d    = '0;
            qp_d     = 1'b0;
            ph_d     = PH_PLAIN;
            bnd_d    = 1'b1;
            sp_cnt_d = '0;
            cs_cnt_d = '0;
            skip     = 1'b1;
          end else begin
            qp_d  = 1'b0;
            tc    = ewhd_pkg::text_char(dec_d, letter_q, ewhd_pkg::CH_QM);
            dec_d = tc.d;
            if (tc.emit) begin
              cmd = ewhd_pkg::add_lit(cmd, tc.b, 1'b1);
            end
          end
        end
        if (!skip) begin
          if (c == ewhd_pkg::CH_QM) begin
            qp_d = 1'b1;
          end else begin
            tc    = ewhd_pkg::text_char(dec_d, letter_q, c);
            dec_d = tc.d;
            if (tc.emit) begin
              cmd = ewhd_pkg::add_lit(cmd, tc.b, 1'b1);
            end
          end
        end
      end
      PH_LIT: begin
        if (qp_q) begin
          if (c == ewhd_pkg::CH_EQ) begin
            cmd      = ewhd_pkg::add_lit(cmd, ewhd_pkg::CH_QM, 1'b0);
            cmd      = ewhd_pkg::add_lit(cmd, ewhd_pkg::CH_EQ, 1'b0);
            dec_d    = '0;
            qp_d     = 1'b0;
            ph_d     = PH_PLAIN;
            bnd_d    = 1'b1;
            sp_cnt_d = '0;
            cs_cnt_d = '0;
            skip     = 1'b1;
          end else begin
            qp_d = 1'b0;
            cmd  = ewhd_pkg::add_lit(cmd, ewhd_pkg::CH_QM, 1'b0);
          end
        end
        if (!skip) begin
          if (c == ewhd_pkg::CH_QM) begin
            qp_d = 1'b1;
          end else begin
            cmd = ewhd_pkg::add_lit(cmd, c, 1'b0);
          end
        end
      end
      default: begin
        do_plain = 1'b1;
      end
    endcase

    // plain text handling, after the phase case and before the end-of-header flush
    if (do_plain) begin
      ph_d = PH_PLAIN;
      if (c == ewhd_pkg::CH_EQ) begin
        ph_d = PH_EQ;
      end else if (bnd_d && ewhd_pkg::is_ws(c) && sp_cnt_d < SPW'(SPACE_HOLD)) begin
        sp_we_o    = 1'b1;
        sp_waddr_o = sp_cnt_d[SP_AW-1:0];
        sp_cnt_d   = sp_cnt_d + 1'b1;
      end else begin
        if (sp_cnt_d != '0) begin
          cmd.sp_n = ewhd_pkg::CNT_W'(sp_cnt_d);
        end
        sp_cnt_d = '0;
        cmd      = ewhd_pkg::add_lit(cmd, c, 1'b0);
        bnd_d    = 1'b0;
      end
    end

    // end of header: flush whatever is held, then back to reset values
    if (end_of_text_i) begin
      unique case (ph_d)
        PH_EQ: begin
          if (sp_cnt_d != '0) begin
            cmd.sp_n = ewhd_pkg::CNT_W'(sp_cnt_d);
          end
          cmd = ewhd_pkg::add_lit(cmd, ewhd_pkg::CH_EQ, 1'b0);
        end
        PH_CHARSET: begin
          cmd.pre  = 1'b1;
          cmd.cs_n = ewhd_pkg::CNT_W'(cs_cnt_d);
        end
        PH_LETTER: begin
          cmd.pre  = 1'b1;
          cmd.cs_n = ewhd_pkg::CNT_W'(cs_cnt_d);
          cmd      = ewhd_pkg::add_lit(cmd, ewhd_pkg::CH_QM, 1'b0);
        end
        PH_AFTER: begin
          cmd.pre  = 1'b1;
          cmd.cs_n = ewhd_pkg::CNT_W'(cs_cnt_d);
          cmd      = ewhd_pkg::add_lit(cmd, ewhd_pkg::CH_QM, 1'b0);
          cmd      = ewhd_pkg::add_lit(cmd, letter_d, 1'b0);
        end
        PH_TEXT: begin
          if (qp_d) begin
            tc = ewhd_pkg::text_char(dec_d, letter_d, ewhd_pkg::CH_QM);
            if (tc.emit) begin
              cmd = ewhd_pkg::add_lit(cmd, tc.b, 1'b1);
            end
          end
        end
        PH_LIT: begin
          if (qp_d) begin
            cmd = ewhd_pkg::add_lit(cmd, ewhd_pkg::CH_QM, 1'b0);
          end
        end
        default: begin
          if (sp_cnt_d != '0) begin
            cmd.sp_n = ewhd_pkg::CNT_W'(sp_cnt_d);
          end
        end
      endcase
      ph_d     = PH_PLAIN;
      cs_cnt_d = '0;
      letter_d = '0;
      sp_cnt_d = '0;
      bnd_d    = 1'b1;
      dec_d    = '0;
      qp_d     = 1'b0;
    end

    sp_we_o = sp_we_o && accept;
    cs_we_o = cs_we_o && accept;
  end

  assign cmd_o  = cmd;
  assign push_o = accept && ((cmd.sp_n != '0) || cmd.pre || (cmd.lit_n != 3'd0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q     <= PH_PLAIN;
      cs_cnt_q <= '0;
      letter_q <= '0;
      sp_cnt_q <= '0;
      bnd_q    <= 1'b1;
      dec_q    <= '0;
      qp_q     <= 1'b0;
    end else if (accept) begin
      ph_q     <= ph_d;
      cs_cnt_q <= cs_cnt_d;
      letter_q <= letter_d;
      sp_cnt_q <= sp_cnt_d;
      bnd_q    <= bnd_d;
      dec_q    <= dec_d;
      qp_q     <= qp_d;
    end
  end

endmodule

### design/ewhd_back.sv
// emitter back: walks one command at a time, reads the stores, drives the result register
// depends on ewhd_pkg
`timescale 1ns / 1ps

module ewhd_back #(
  parameter int CHARSET_MAX = 16,
  parameter int SPACE_HOLD = 16,
  localparam int CS_AW = (CHARSET_MAX > 1) ? $clog2(CHARSET_MAX) : 1,
  localparam int SP_AW = (SPACE_HOLD > 1) ? $clog2(SPACE_HOLD) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fifo_valid_i,
  input  ewhd_pkg::cmd_t   fifo_cmd_i,
  output logic             pop_o,
  output logic             busy_o,
  output logic             sp_re_o,
  output logic [SP_AW-1:0] sp_raddr_o,
  input  logic [7:0]       sp_rdata_i,
  output logic             cs_re_o,
  output logic [CS_AW-1:0] cs_raddr_o,
  input  logic [7:0]       cs_rdata_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             from_word_o,
  output logic             last_of_run_o
);

  localparam logic [2:0] SEC_SP   = 3'd0;
  localparam logic [2:0] SEC_PEQ  = 3'd1;
  localparam logic [2:0] SEC_PQ   = 3'd2;
  localparam logic [2:0] SEC_CS   = 3'd3;
  localparam logic [2:0] SEC_LIT  = 3'd4;
  localparam logic [2:0] SEC_DONE = 3'd5;

  localparam logic [1:0] SRC_LIT = 2'd0;
  localparam logic [1:0] SRC_SP  = 2'd1;
  localparam logic [1:0] SRC_CS  = 2'd2;

  logic                       act_q, act_d;
  ewhd_pkg::cmd_t             cmd_q, cmd_d;
  logic [2:0]                 sec_q, sec_d;
  logic [ewhd_pkg::CNT_W-1:0] idx_q, idx_d, idx_nx;

  logic       mid_valid_q, mid_valid_d;
  logic [1:0] mid_src_q;
  logic [7:0] mid_byte_q;
  logic       mid_fw_q, mid_last_q;

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       out_fw_q, out_last_q;

  logic       advance_out, mid_take, issue;
  logic [1:0] src;
  logic [7:0] ibyte;
  logic       ifw, ilast;
  logic       has_lit;
  logic [2:0] after_sp, after_cs;

  assign advance_out = !out_valid_q || !out_stall_i;
  assign mid_take    = mid_valid_q && advance_out;
  assign issue       = act_q && (!mid_valid_q || advance_out);
  assign idx_nx      = idx_q + 1'b1;
  assign has_lit     = (cmd_q.lit_n != 3'd0);
  assign after_cs    = has_lit ? SEC_LIT : SEC_DONE;
  assign after_sp    = cmd_q.pre ? SEC_PEQ : after_cs;

  always_comb begin
    act_d = act_q;
    cmd_d = cmd_q;
    sec_d = sec_q;
    idx_d = idx_q;
    src   = SRC_LIT;
    ibyte = 8'h00;
    ifw   = 1'b0;
    ilast = 1'b0;
    pop_o = 1'b0;

    unique case (sec_q)
      SEC_SP: begin
        src   = SRC_SP;
        ilast = (idx_nx == cmd_q.sp_n) && !cmd_q.pre && !has_lit;
        if (issue) begin
          idx_d = idx_nx;
          if (idx_nx == cmd_q.sp_n) begin
            sec_d = after_sp;
            idx_d = '0;
          end
        end
      end
      SEC_PEQ: begin
        ibyte = ewhd_pkg::CH_EQ;
        if (issue) begin
          sec_d = SEC_PQ;
        end
      end
      SEC_PQ: begin
        ibyte = ewhd_pkg::CH_QM;
        ilast = (cmd_q.cs_n == '0) && !has_lit;
        if (issue) begin
          sec_d = (cmd_q.cs_n != '0) ? SEC_CS : after_cs;
          idx_d = '0;
        end
      end
      SEC_CS: begin
        src   = SRC_CS;
        ilast = (idx_nx == cmd_q.cs_n) && !has_lit;
        if (issue) begin
          idx_d = idx_nx;
          if (idx_nx == cmd_q.cs_n) begin
            sec_d = after_cs;
            idx_d = '0;
          end
        end
      end
      SEC_LIT: begin
        ibyte = cmd_q.lit[idx_q[1:0]];
        ifw   = cmd_q.lit_fw[idx_q[1:0]];
        ilast = (idx_nx[2:0] == cmd_q.lit_n);
        if (issue) begin
          idx_d = idx_nx;
          if (idx_nx[2:0] == cmd_q.lit_n) begin
            sec_d = SEC_DONE;
          end
        end
      end
      default: begin
      end
    endcase

    if (issue && sec_d == SEC_DONE) begin
      act_d = 1'b0;
    end

    if (!act_q && fifo_valid_i) begin
      pop_o = 1'b1;
      act_d = 1'b1;
      cmd_d = fifo_cmd_i;
      idx_d = '0;
      if (fifo_cmd_i.sp_n != '0) begin
        sec_d = SEC_SP;
      end else if (fifo_cmd_i.pre) begin
        sec_d = SEC_PEQ;
      end else begin
        sec_d = SEC_LIT;
      end
    end
  end

  assign sp_re_o    = issue && (sec_q == SEC_SP);
  assign cs_re_o    = issue && (sec_q == SEC_CS);
  assign sp_raddr_o = idx_q[SP_AW-1:0];
  assign cs_raddr_o = idx_q[CS_AW-1:0];
  assign busy_o     = act_q && ewhd_pkg::uses_store(cmd_q);

  always_comb begin
    mid_valid_d = mid_valid_q;
    if (issue) begin
      mid_valid_d = 1'b1;
    end else if (mid_take) begin
      mid_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (mid_take) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q       <= 1'b0;
      sec_q       <= SEC_DONE;
      idx_q       <= '0;
      mid_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      act_q       <= act_d;
      sec_q       <= sec_d;
      idx_q       <= idx_d;
      mid_valid_q <= mid_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    if (issue) begin
      mid_src_q  <= src;
      mid_byte_q <= ibyte;
      mid_fw_q   <= ifw;
      mid_last_q <= ilast;
    end
    if (mid_take) begin
      unique case (mid_src_q)
        SRC_SP:  out_byte_q <= sp_rdata_i;
        SRC_CS:  out_byte_q <= cs_rdata_i;
        default: out_byte_q <= mid_byte_q;
      endcase
      out_fw_q   <= mid_fw_q;
      out_last_q <= mid_last_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign from_word_o   = out_fw_q;
  assign last_of_run_o = out_last_q;

endmodule

### design/encoded_word_header_decoder.sv
// encoded-word header decoder: commands pass the command queue, then the emitter's
// command, mid and output registers; throughput: one byte accepted per cycle while the
// command queue has room and no pending command still reads a store; the emitter gives
// one result per cycle unless out_stall_i holds it, and none while it loads a command
// reset: asynchronous, clears parser and emitter control, stores are not cleared
`timescale 1ns / 1ps

module encoded_word_header_decoder #(
  parameter int CHARSET_MAX = 16,
  parameter int SPACE_HOLD = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input transaction: one header byte
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_text_i,
  // output transaction: one result byte
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       from_word_o,
  output logic       last_of_run_o
);

  localparam int CS_AW = (CHARSET_MAX > 1) ? $clog2(CHARSET_MAX) : 1;
  localparam int SP_AW = (SPACE_HOLD > 1) ? $clog2(SPACE_HOLD) : 1;

  // front to queue
  logic           push;
  ewhd_pkg::cmd_t push_cmd;
  // queue to back
  logic           fifo_valid, fifo_full, fifo_busy, pop;
  ewhd_pkg::cmd_t head_cmd;
  logic           back_busy;

  // store ports
  logic             sp_we, cs_we, sp_re, cs_re;
  logic [SP_AW-1:0] sp_waddr, sp_raddr;
  logic [CS_AW-1:0] cs_waddr, cs_raddr;
  logic [7:0]       wdata, sp_rdata, cs_rdata;

  // the front must not overwrite a store entry that a pending command still reads
  logic store_busy;
  assign store_busy = fifo_busy || back_busy;

  ewhd_front #(
    .CHARSET_MAX(CHARSET_MAX),
    .SPACE_HOLD (SPACE_HOLD)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_byte_i    (in_byte_i),
    .end_of_text_i(end_of_text_i),
    .in_stall_o   (in_stall_o),
    .fifo_full_i  (fifo_full),
    .store_busy_i (store_busy),
    .push_o       (push),
    .cmd_o        (push_cmd),
    .sp_we_o      (sp_we),
    .sp_waddr_o   (sp_waddr),
    .cs_we_o      (cs_we),
    .cs_waddr_o   (cs_waddr),
    .wdata_o      (wdata)
  );

  // held whitespace run
  ewhd_ram #(
    .WIDTH(8),
    .DEPTH(SPACE_HOLD)
  ) u_sp_ram (
    .clk_i  (clk_i),
    .we_i   (sp_we),
    .waddr_i(sp_waddr),
    .wdata_i(wdata),
    .re_i   (sp_re),
    .raddr_i(sp_raddr),
    .rdata_o(sp_rdata)
  );

  // charset bytes of the word being parsed
  ewhd_ram #(
    .WIDTH(8),
    .DEPTH(CHARSET_MAX)
  ) u_cs_ram (
    .clk_i  (clk_i),
    .we_i   (cs_we),
    .waddr_i(cs_waddr),
    .wdata_i(wdata),
    .re_i   (cs_re),
    .raddr_i(cs_raddr),
    .rdata_o(cs_rdata)
  );

  ewhd_cmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .cmd_i       (push_cmd),
    .pop_i       (pop),
    .valid_o     (fifo_valid),
    .cmd_o       (head_cmd),
    .full_o      (fifo_full),
    .store_busy_o(fifo_busy)
  );

  ewhd_back #(
    .CHARSET_MAX(CHARSET_MAX),
    .SPACE_HOLD (SPACE_HOLD)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_valid_i (fifo_valid),
    .fifo_cmd_i   (head_cmd),
    .pop_o        (pop),
    .busy_o       (back_busy),
    .sp_re_o      (sp_re),
    .sp_raddr_o   (sp_raddr),
    .sp_rdata_i   (sp_rdata),
    .cs_re_o      (cs_re),
    .cs_raddr_o   (cs_raddr),
    .cs_rdata_i   (cs_rdata),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .from_word_o  (from_word_o),
    .last_of_run_o(last_of_run_o)
  );

endmodule

### tb/tb_encoded_word_header_decoder.sv
// testbench for encoded_word_header_decoder: streams mail header bytes through the block
// and checks every result byte against a scoreboard that predicts the decoding
// depends on ewhd_pkg (character constants) and the decoder rtl
`timescale 1ns / 1ps

module tb_encoded_word_header_decoder;
  import ewhd_pkg::*;

  // parser phases of the predictor
  typedef enum int {
    PH_PLAIN, PH_EQ, PH_CHARSET, PH_LETTER, PH_AFTER, PH_TEXT, PH_LIT
  } phase_e;

  localparam int CS_MAX = 16;
  localparam int SP_MAX = 16;
  localparam int MAX_OUT = 2 + CS_MAX + 4;

  typedef struct packed {
    logic [7:0] b;
    logic       fw;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [7:0] b;
    logic       eot;
  } hdr_t;

  // predicts decoded header bytes and checks them in order
  class header_scoreboard;
    out_t       expected_bytes[$];
    out_t       step_out[$];
    int         errors;
    phase_e     phase;
    logic [7:0] charset[CS_MAX];
    logic [7:0] spaces[SP_MAX];
    int         cs_n, sp_n;
    logic [7:0] letter;
    bit         boundary;
    logic [11:0] sextet;
    int         pend;
    bit         stopped;
    int         hexph;
    logic [7:0] hn;
    bit         qpend;

    function new();
      errors = 0;
      clear_all();
    endfunction

    function void clear_dec();
      sextet = 0; pend = 0; stopped = 0; hexph = 0; hn = 0; qpend = 0;
    endfunction

    function void clear_all();
      phase = PH_PLAIN; cs_n = 0; sp_n = 0; letter = 0; boundary = 1;
      clear_dec();
    endfunction

    function void put(logic [7:0] b, logic fw);
      if (step_out.size() < MAX_OUT) step_out.push_back('{b, fw, 1'b0});
    endfunction

    function bit ws(logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
    endfunction

    function logic [7:0] hexv(logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "A" && c <= "Z") c = c + 8'd32;
      return c - "a" + 8'd10;
    endfunction

    // -1 for bytes outside the base64 alphabet
    function int sextet_of(logic [7:0] c);
      if (c >= "A" && c <= "Z") return c - "A";
      if (c >= "a" && c <= "z") return c - "a" + 26;
      if (c >= "0" && c <= "9") return c - "0" + 52;
      if (c == "+") return 62;
      if (c == "/") return 63;
      return -1;
    endfunction

    function void release_spaces();
      for (int i = 0; i < sp_n; i++) put(spaces[i], 0);
      sp_n = 0;
    endfunction

    function void put_prefix();
      put(CH_EQ, 0);
      put(CH_QM, 0);
      for (int i = 0; i < cs_n; i++) put(charset[i], 0);
    endfunction

    function void plain(logic [7:0] c);
      phase = PH_PLAIN;
      if (c == CH_EQ) begin
        phase = PH_EQ;
        return;
      end
      if (boundary && ws(c) && sp_n < SP_MAX) begin
        spaces[sp_n] = c;
        sp_n++;
        return;
      end
      release_spaces();
      put(c, 0);
      boundary = 0;
    endfunction

    function void to_plain(logic [7:0] c);
      boundary = 0;
      plain(c);
    endfunction

    function bit is_q();
      return letter == CH_UQ || letter == CH_LQ;
    endfunction

    function bit is_b();
      return letter == CH_UB || letter == CH_LB;
    endfunction

    function void decode_text(logic [7:0] c);
      int r;
      if (is_q()) begin
        if (hexph == 1) begin
          hn = hexv(c);
          hexph = 2;
        end else if (hexph == 2) begin
          put((hn << 4) + hexv(c), 1);
          hexph = 0;
        end else if (c == CH_EQ) begin
          hexph = 1;
        end else if (c == CH_UNDER) begin
          put(CH_SPACE, 1);
        end else begin
          put(c, 1);
        end
        return;
      end
      if (stopped) return;
      if (c == CH_EQ) begin
        stopped = 1;
        return;
      end
      r = sextet_of(c);
      if (r < 0) return;
      sextet = (sextet << 6) | r[5:0];
      pend += 6;
      if (pend >= 8) begin
        put(8'(sextet >> (pend - 8)), 1);
        pend -= 8;
      end
    endfunction

    function void word_done();
      clear_dec();
      phase = PH_PLAIN; boundary = 1; sp_n = 0; cs_n = 0;
    endfunction

    function void parse(logic [7:0] c);
      case (phase)
        PH_EQ: begin
          if (c == CH_QM) begin
            sp_n = 0; cs_n = 0; phase = PH_CHARSET;
          end else begin
            release_spaces();
            put(CH_EQ, 0);
            to_plain(c);
          end
        end
        PH_CHARSET: begin
          if (c == CH_QM) begin
            phase = PH_LETTER;
          end else if (cs_n < CS_MAX) begin
            charset[cs_n] = c;
            cs_n++;
          end else begin
            put_prefix();
            cs_n = 0;
            to_plain(c);
          end
        end
        PH_LETTER: begin
          letter = c;
          if (c == CH_QM) begin
            put_prefix(); put(CH_QM, 0); put(CH_QM, 0);
            qpend = 0;
            phase = PH_LIT;
          end else begin
            phase = PH_AFTER;
          end
        end
        PH_AFTER: begin
          if (c == CH_QM) begin
            clear_dec();
            if (is_q() || is_b()) begin
              phase = PH_TEXT;
            end else begin
              put_prefix(); put(CH_QM, 0); put(letter, 0); put(CH_QM, 0);
              phase = PH_LIT;
            end
          end else begin
            put_prefix(); put(CH_QM, 0); put(letter, 0);
            cs_n = 0;
            to_plain(c);
          end
        end
        PH_TEXT: begin
          if (qpend) begin
            if (c == CH_EQ) begin
              word_done();
              return;
            end
            qpend = 0;
            decode_text(CH_QM);
          end
          if (c == CH_QM) qpend = 1;
          else decode_text(c);
        end
        PH_LIT: begin
          if (qpend) begin
            if (c == CH_EQ) begin
              put(CH_QM, 0); put(CH_EQ, 0);
              word_done();
              return;
            end
            qpend = 0;
            put(CH_QM, 0);
          end
          if (c == CH_QM) qpend = 1;
          else put(c, 0);
        end
        default: plain(c);
      endcase
    endfunction

    // held bytes at the end of a header
    function void flush_header();
      case (phase)
        PH_PLAIN: release_spaces();
        PH_EQ: begin
          release_spaces();
          put(CH_EQ, 0);
        end
        PH_CHARSET: put_prefix();
        PH_LETTER: begin
          put_prefix(); put(CH_QM, 0);
        end
        PH_AFTER: begin
          put_prefix(); put(CH_QM, 0); put(letter, 0);
        end
        PH_TEXT: if (qpend) decode_text(CH_QM);
        PH_LIT: if (qpend) put(CH_QM, 0);
        default: ;
      endcase
    endfunction

    // accepted input transaction
    function void note_byte(logic [7:0] c, logic eot);
      step_out.delete();
      parse(c);
      if (eot) begin
        flush_header();
        clear_all();
      end
      if (step_out.size() > 0) step_out[step_out.size()-1].last = 1'b1;
      foreach (step_out[i]) expected_bytes.push_back(step_out[i]);
    endfunction

    // accepted output transaction
    function void check_byte(out_t got);
      out_t exp_b;
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected result byte=%h fw=%b last=%b",
                 $time, got.b, got.fw, got.last);
        errors++;
        return;
      end
      exp_b = expected_bytes.pop_front();
      if (got.b !== exp_b.b) begin
        $display("%0t: out_byte expected %h actual %h", $time, exp_b.b, got.b);
        errors++;
      end
      if (got.fw !== exp_b.fw) begin
        $display("%0t: from_word expected %b actual %b", $time, exp_b.fw, got.fw);
        errors++;
      end
      if (got.last !== exp_b.last) begin
        $display("%0t: last_of_run expected %b actual %b", $time, exp_b.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] in_byte_i = 8'h00;
  logic       end_of_text_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       from_word_o;
  logic       last_of_run_o;

  header_scoreboard sb = new();
  hdr_t stream[$];
  bit   idling = 1'b1;   // random gaps on both sides
  bit   hold_req = 1'b0; // one long receiver hold-off

  encoded_word_header_decoder dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .in_byte_i, .end_of_text_i,
    .out_valid_o, .out_stall_i, .out_byte_o, .from_word_o, .last_of_run_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // output transactions go straight to the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_byte('{out_byte_o, from_word_o, last_of_run_o});
  end

  // receiver: random stall bursts plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
        hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic add_str(string s, bit eot_at_end);
    for (int i = 0; i < s.len(); i++)
      stream.push_back('{s[i], eot_at_end && i == s.len() - 1});
  endtask

  task automatic add_byte(logic [7:0] b);
    stream.push_back('{b, 1'b0});
  endtask

  // byte drawn from characters that matter inside encoded text
  function automatic logic [7:0] text_byte();
    case ($urandom_range(0, 7))
      0: return CH_EQ;
      1: return CH_UNDER;
      2: return CH_QM;
      3: return 8'($urandom_range(0, 255));
      4: return 8'($urandom_range("0", "9"));
      5: return 8'($urandom_range("A", "F"));
      default: return 8'($urandom_range("a", "z"));
    endcase
  endfunction

  // whitespace run, then mostly a well-formed word with random content
  task automatic add_random_word();
    int n;
    n = $urandom_range(0, 3) == 0 ? $urandom_range(0, 20) : $urandom_range(0, 2);
    repeat (n) begin
      case ($urandom_range(0, 3))
        0: add_byte(CH_SPACE);
        1: add_byte(CH_TAB);
        2: add_byte(CH_LF);
        default: add_byte(CH_CR);
      endcase
    end
    case ($urandom_range(0, 9))
      0: repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
      1: add_byte(CH_EQ);
      default: begin
        add_byte(CH_EQ);
        add_byte(CH_QM);
        n = $urandom_range(0, 7) == 0 ? $urandom_range(15, 19) : $urandom_range(0, 8);
        repeat (n) add_byte(8'($urandom_range("a", "z")));
        add_byte(CH_QM);
        case ($urandom_range(0, 9))
          0: add_byte(8'($urandom_range(0, 255)));
          1: add_byte(CH_QM);
          2, 3: add_byte(CH_UQ);
          4: add_byte(CH_LQ);
          5, 6: add_byte(CH_UB);
          default: add_byte(CH_LB);
        endcase
        if ($urandom_range(0, 9) != 0) add_byte(CH_QM);
        repeat ($urandom_range(0, 10)) add_byte(text_byte());
        if ($urandom_range(0, 7) != 0) begin
          add_byte(CH_QM);
          add_byte(CH_EQ);
        end
      end
    endcase
    if ($urandom_range(0, 7) == 0) stream[stream.size()-1].eot = 1'b1;
  endtask

  // hands one byte over, waiting for the handshake
  task automatic send_byte(hdr_t h);
    in_valid_i <= 1'b1;
    in_byte_i <= h.b;
    end_of_text_i <= h.eot;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_byte(h.b, h.eot);
  endtask

  task automatic send_stream(int from_idx);
    for (int i = from_idx; i < stream.size(); i++) begin
      if (i == from_idx + 120) hold_req = 1'b1;
      if (i == from_idx + 200 && sb.expected_bytes.size() != 0) begin
        // sender waits for the block to drain completely
        in_valid_i <= 1'b0;
        while (sb.expected_bytes.size() != 0) @(posedge clk_i);
      end
      if (i > stream.size() - 40) idling = 1'b0;
      if (idling && $urandom_range(0, 4) == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end
      send_byte(stream[i]);
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin
    // directed: q escapes incl. odd hex digits, base64 with padding and junk,
    // unknown letter, empty letter, bad word end, long charset, dropped spaces
    add_str(" =?x?Q?=41_=zZ?a?= \t=?u?b?QU*Jj=x?=", 1'b1);
    add_str("=?s?X?a?b?=", 1'b0);
    add_str("=??Qz=", 1'b1);
    add_str("=?abcdefghijklmnopq", 1'b0);
    add_str("=?c??", 1'b1);
    add_byte(8'hff); add_byte(8'h00);
    add_str("=?c?q?=4", 1'b1);
    while (stream.size() < 320) add_random_word();
    stream[stream.size()-1].eot = 1'b1;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_stream(0);
    while (sb.expected_bytes.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_bytes.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule
